[hw/rtl/pspol_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pspol_pkg
// Shared types and constants for the per-slot priority token bucket policer.
// ----------------------------------------------------------------------------
package pspol_pkg;

  // Field widths
  localparam int RATE_W = 24;
  localparam int TPS_W  = 16;
  localparam int TIME_W = 32;
  localparam int LEN_W  = 16;
  localparam int CNT_W  = 40;
  localparam int SLOT_W = 8;
  localparam int CLS_W  = 2;

  // Stream word widths
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 88;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_ADDR_W-1:0] CFG_RATE_HIGH   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RATE_MEDIUM = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_RATE_LOW    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_RATE_UNSPEC = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_TPS         = 3'd4;

  localparam logic [RATE_W-1:0] RST_RATE_HIGH   = 24'd10240;
  localparam logic [RATE_W-1:0] RST_RATE_MEDIUM = 24'd5120;
  localparam logic [RATE_W-1:0] RST_RATE_LOW    = 24'd1024;
  localparam logic [RATE_W-1:0] RST_RATE_UNSPEC = 24'd1024000;
  localparam logic [TPS_W-1:0]  RST_TPS         = 16'd1000;

  // Request kinds
  typedef enum logic [1:0] {
    REQ_PACKET = 2'd0,
    REQ_SET    = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_READ   = 2'd3
  } req_t;

  // Class reported when a slot has no bucket
  localparam logic [CLS_W-1:0] CLASS_NONE = 2'd3;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_WRITE
  } state_t;

endpackage
`default_nettype wire

[hw/rtl/pspol_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pspol_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pspol_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

[hw/rtl/per_slot_priority_token_bucket_policer_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_slot_priority_token_bucket_policer_top
// Per-slot byte counters and optional class-based token bucket policer.
// ----------------------------------------------------------------------------
//
//  Channel   | Dir | Handshake              | Contents
//  ----------+-----+------------------------+-----------------------------------
//  s_axis    | in  | tvalid / tready        | one request: kind, slot, packet info
//  m_axis    | out | tvalid / tready        | one result per request
//  cfg       | in  | cfg_we (always taken)  | class rates, ticks per second
//
//  Each request passes through the accepting cycle, which issues the slot
//  table read, then refill multiply (READ), add and cap (SUM), and check and
//  write back (WRITE); the result register is loaded as WRITE completes. Only
//  one request is held at a time, so the table read-modify-write never
//  overlaps itself.
//  After reset the slot table is swept to its reset contents with
//  s_axis_tready low; configuration writes are taken meanwhile.
//  A result waiting on m_axis does not block acceptance of the next request;
//  write-back stalls only if the previous result is still untaken.
//
module per_slot_priority_token_bucket_policer_top #(
  parameter int SLOTS      = 256,
  parameter int TOKEN_BITS = 40
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // tdata: slot[7:0], known[8], outbound[9], length[25:10], level[27:26], zero pad
  input  wire logic [pspol_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: req_type[1:0]
  input  wire logic [pspol_pkg::IN_USER_W-1:0]     s_axis_tuser,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // tdata: allow[0], up_count[40:1], down_count[80:41], has_class[81],
  //        class_out[83:82], zero pad
  output logic      [pspol_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  input  wire logic                                cfg_we,
  input  wire logic [pspol_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [pspol_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TB     = TOKEN_BITS;
  // rate * elapsed ticks
  localparam int FILL_W = pspol_pkg::RATE_W + pspol_pkg::TIME_W;
  // rate * ticks per second
  localparam int CAP_W  = pspol_pkg::RATE_W + pspol_pkg::TPS_W;
  localparam int SUM_W  = FILL_W + 1;

  // One slot table word
  typedef struct packed {
    logic [pspol_pkg::CNT_W-1:0]  up;
    logic [pspol_pkg::CNT_W-1:0]  down;
    logic [pspol_pkg::TIME_W-1:0] last;
    logic [TB-1:0]                tok;
    logic                         started;
    logic [pspol_pkg::CLS_W-1:0]  cls;
    logic                         valid;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [pspol_pkg::RATE_W-1:0] rate [4];
  logic [pspol_pkg::TPS_W-1:0]  tps;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate[0] <= pspol_pkg::RST_RATE_HIGH;
      rate[1] <= pspol_pkg::RST_RATE_MEDIUM;
      rate[2] <= pspol_pkg::RST_RATE_LOW;
      rate[3] <= pspol_pkg::RST_RATE_UNSPEC;
      tps     <= pspol_pkg::RST_TPS;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pspol_pkg::CFG_RATE_HIGH:   rate[0] <= cfg_data;
        pspol_pkg::CFG_RATE_MEDIUM: rate[1] <= cfg_data;
        pspol_pkg::CFG_RATE_LOW:    rate[2] <= cfg_data;
        pspol_pkg::CFG_RATE_UNSPEC: rate[3] <= cfg_data;
        pspol_pkg::CFG_TPS:         tps     <= cfg_data[pspol_pkg::TPS_W-1:0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Request fields
  // --------------------------------------------------------------------------
  logic [pspol_pkg::SLOT_W-1:0] in_slot;
  logic [ADDR_W+pspol_pkg::SLOT_W-1:0] in_slot_wide;
  logic [ADDR_W-1:0] in_addr;

  assign in_slot      = s_axis_tdata[7:0];
  assign in_slot_wide = {{ADDR_W{1'b0}}, in_slot};
  assign in_addr      = in_slot_wide[ADDR_W-1:0];

  logic                           accept;
  pspol_pkg::req_t                req;
  logic [ADDR_W-1:0]              addr;
  logic                           in_range;
  logic                           known;
  logic                           outbound;
  logic [pspol_pkg::LEN_W-1:0]    len;
  logic [pspol_pkg::CLS_W-1:0]    level;

  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (accept) begin
      req      <= pspol_pkg::req_t'(s_axis_tuser);
      addr     <= in_addr;
      in_range <= ({24'd0, in_slot} < 32'(SLOTS));
      known    <= s_axis_tdata[8];
      outbound <= s_axis_tdata[9];
      len      <= s_axis_tdata[25:10];
      level    <= s_axis_tdata[27:26];
    end
  end

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  pspol_pkg::state_t state, state_next;
  logic [ADDR_W-1:0] clr_cnt;
  logic              wb_go;

  assign wb_go = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pspol_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    unique case (state)
      pspol_pkg::ST_CLEAR: begin
        if (clr_cnt == ADDR_W'(SLOTS - 1)) begin
          state_next = pspol_pkg::ST_IDLE;
        end
      end
      pspol_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = pspol_pkg::ST_READ;
        end
      end
      pspol_pkg::ST_READ:  state_next = pspol_pkg::ST_SUM;
      pspol_pkg::ST_SUM:   state_next = pspol_pkg::ST_WRITE;
      pspol_pkg::ST_WRITE: begin
        if (wb_go) begin
          state_next = pspol_pkg::ST_IDLE;
        end
      end
      default: state_next = pspol_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == pspol_pkg::ST_CLEAR) begin
      clr_cnt <= clr_cnt + ADDR_W'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Slot table
  // --------------------------------------------------------------------------
  entry_t            rd_ent;
  entry_t            ent_new;
  entry_t            ent_rst;
  logic              wr_need;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  entry_t            mem_wdata;

  always_comb begin
    ent_rst         = '0;
    ent_rst.cls     = pspol_pkg::CLASS_NONE;
  end

  always_comb begin
    if (state == pspol_pkg::ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = ent_rst;
    end else begin
      mem_we    = (state == pspol_pkg::ST_WRITE) && wb_go && wr_need;
      mem_waddr = addr;
      mem_wdata = ent_new;
    end
  end

  pspol_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (in_addr),
    .rd_data (rd_ent)
  );

  // --------------------------------------------------------------------------
  // Refill: multiply stage (READ), add and cap stage (SUM)
  // --------------------------------------------------------------------------
  logic [pspol_pkg::TIME_W-1:0] time_now;
  logic [pspol_pkg::RATE_W-1:0] rate_sel;
  logic [pspol_pkg::TIME_W-1:0] dt;

  entry_t            cur;
  logic [FILL_W-1:0] fill;
  logic [CAP_W-1:0]  cap_full;
  logic [TB-1:0]     tok0;
  logic              rate_zero;
  logic [TB-1:0]     tok_t;

  assign rate_sel = rate[rd_ent.cls];
  // a bucket not yet started refills by zero ticks from zero tokens
  assign dt = rd_ent.started ? (time_now - rd_ent.last) : '0;

  always_ff @(posedge clk) begin
    if (state == pspol_pkg::ST_READ) begin
      cur       <= rd_ent;
      fill      <= rate_sel * dt;
      cap_full  <= rate_sel * tps;
      tok0      <= rd_ent.started ? rd_ent.tok : '0;
      rate_zero <= (rate_sel == '0);
    end
  end

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] cap_w;
  logic [SUM_W-1:0] tokmax_w;
  logic [SUM_W-1:0] cap_c;
  logic [SUM_W-1:0] t_cap;

  always_comb begin
    sum      = SUM_W'(tok0) + SUM_W'(fill);
    cap_w    = SUM_W'(cap_full);
    tokmax_w = SUM_W'({TB{1'b1}});
    cap_c    = (cap_w < tokmax_w) ? cap_w : tokmax_w;
    t_cap    = (sum < cap_c) ? sum : cap_c;
  end

  always_ff @(posedge clk) begin
    if (state == pspol_pkg::ST_SUM) begin
      tok_t <= t_cap[TB-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Check and write back
  // --------------------------------------------------------------------------
  logic [TB-1:0]                len_tb;
  logic                         covers;
  logic [pspol_pkg::CNT_W:0]    up_sum;
  logic [pspol_pkg::CNT_W:0]    dn_sum;
  logic                         allow;
  logic [pspol_pkg::CNT_W-1:0]  upc;
  logic [pspol_pkg::CNT_W-1:0]  dnc;
  logic                         has_cls;
  logic [pspol_pkg::CLS_W-1:0]  cls_out;

  assign len_tb = {{(TB - pspol_pkg::LEN_W){1'b0}}, len};
  assign covers = (tok_t >= len_tb);
  assign up_sum = {1'b0, cur.up}   + (pspol_pkg::CNT_W + 1)'(len);
  assign dn_sum = {1'b0, cur.down} + (pspol_pkg::CNT_W + 1)'(len);

  always_comb begin
    ent_new = cur;
    wr_need = 1'b0;
    allow   = 1'b1;
    upc     = '0;
    dnc     = '0;
    unique case (req)
      pspol_pkg::REQ_PACKET: begin
        if (known && in_range) begin
          wr_need = 1'b1;
          if (outbound) begin
            ent_new.up = up_sum[pspol_pkg::CNT_W] ? pspol_pkg::CNT_MAX
                                                  : up_sum[pspol_pkg::CNT_W-1:0];
          end else begin
            ent_new.down = dn_sum[pspol_pkg::CNT_W] ? pspol_pkg::CNT_MAX
                                                    : dn_sum[pspol_pkg::CNT_W-1:0];
          end
          if (cur.valid) begin
            if (rate_zero) begin
              allow = 1'b0;  // bucket left untouched
            end else begin
              ent_new.started = 1'b1;
              ent_new.last    = time_now;
              if (covers) begin
                ent_new.tok = tok_t - len_tb;
              end else begin
                ent_new.tok = tok_t;
                allow       = 1'b0;
              end
            end
          end
        end
      end
      pspol_pkg::REQ_SET: begin
        if (in_range) begin
          wr_need         = 1'b1;
          ent_new.cls     = level;
          ent_new.valid   = 1'b1;
          ent_new.tok     = '0;
          ent_new.started = 1'b0;
        end
      end
      pspol_pkg::REQ_TICK: ;
      pspol_pkg::REQ_READ: begin
        if (in_range) begin
          wr_need      = 1'b1;
          upc          = cur.up;
          dnc          = cur.down;
          ent_new.up   = '0;
          ent_new.down = '0;
        end
      end
      default: ;
    endcase
    if ((req != pspol_pkg::REQ_TICK) && in_range) begin
      has_cls = ent_new.valid;
      cls_out = ent_new.cls;
    end else begin
      has_cls = 1'b0;
      cls_out = pspol_pkg::CLASS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now <= '0;
    end else if ((state == pspol_pkg::ST_WRITE) && wb_go
                 && (req == pspol_pkg::REQ_TICK)) begin
      time_now <= time_now + pspol_pkg::TIME_W'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == pspol_pkg::ST_WRITE) && wb_go) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == pspol_pkg::ST_WRITE) && wb_go) begin
      m_axis_tdata <= {4'd0, cls_out, has_cls, dnc, upc, allow};
    end
  end

endmodule
`default_nettype wire

[hw/rtl/pspol_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pspol_chk
// Port-level checks for the policer, bound to the top level.
// ----------------------------------------------------------------------------
module pspol_chk (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic [pspol_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input wire logic [pspol_pkg::IN_USER_W-1:0]  s_axis_tuser,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic [pspol_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic                             cfg_we,
  input wire logic [pspol_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input wire logic [pspol_pkg::CFG_DATA_W-1:0] cfg_data
);

  // no result pending straight after reset
  a_rst_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // one request in flight at a time
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while another in flight");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // a slot without a bucket reports the no-class code
  a_no_class: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[81] |-> m_axis_tdata[83:82] == pspol_pkg::CLASS_NONE)
    else $error("class reported without bucket");

  // only packets are dropped, and packets return no counts
  a_drop_cnt: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[80:1] == '0)
    else $error("dropped result carries counts");

endmodule

bind per_slot_priority_token_bucket_policer_top pspol_chk u_pspol_chk (.*);
`default_nettype wire
